>>> rtl/rfda_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and microcode fields for the resonant filter / decay amp.
// No dependencies; imported by every module of the block.
package rfda_pkg;

  localparam int GainFracBits = 16;
  localparam int GainW        = GainFracBits + 1;
  localparam int CoefW        = 16;
  localparam int SmpW         = 8;
  localparam int StepW        = 17;
  localparam int StepFrac     = 16;
  localparam int AccW         = 16;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 17;

  localparam int MulAW = ((CoefW > GainW) ? CoefW : GainW) + 1;
  localparam int MulBW = SmpW + 1;
  localparam int ProdW = MulAW + MulBW;

  localparam int StepUp  = (GainFracBits >= StepFrac) ? GainFracBits - StepFrac : 0;
  localparam int StepDn  = (GainFracBits < StepFrac) ? StepFrac - GainFracBits : 0;
  localparam int StepXW  = StepW + StepUp;
  localparam int CmpW    = (GainW > StepXW) ? GainW : StepXW;

  localparam logic [GainW-1:0] GainOne = {1'b1, {GainFracBits{1'b0}}};

  localparam int StepCntW = 3;
  localparam logic [StepCntW-1:0] StepOut = 3'd7;

  typedef enum logic [1:0] {
    REG_FEED  = 2'd0,
    REG_FB1   = 2'd1,
    REG_FB2   = 2'd2,
    REG_DECAY = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MA_FEED = 2'd0,
    MA_FB1  = 2'd1,
    MA_FB2  = 2'd2,
    MA_GAIN = 2'd3
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_X   = 2'd0,
    MB_Y1  = 2'd1,
    MB_Y2  = 2'd2,
    MB_MAG = 2'd3
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_WAIT_OUT = 2'd2,
    JMP_START    = 2'd3
  } jmp_e;

  typedef struct packed {
    logic    in_ready;
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    logic    mul_en;
    acc_op_e acc_op;
    logic    filt_upd;
    logic    out_load;
    jmp_e    jmp;
  } ucode_t;

  localparam ucode_t UcNop = '{
    in_ready: 1'b0, mul_a: MA_FEED, mul_b: MB_X, mul_en: 1'b0,
    acc_op: ACC_HOLD, filt_upd: 1'b0, out_load: 1'b0, jmp: JMP_NEXT
  };

  typedef struct packed {
    logic out_busy;
    logic out_valid;
  } dp_status_t;

  typedef struct packed {
    logic [CoefW-1:0] feed;
    logic [CoefW-1:0] fb1;
    logic [CoefW-1:0] fb2;
    logic [StepW-1:0] decay;
  } cfg_t;

endpackage

>>> rtl/rfda_seq.sv
`timescale 1ns / 1ps
// Step counter and microcode ROM for the filter / decay amp.
// Depends on rfda_pkg.
module rfda_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  rfda_pkg::dp_status_t          status_i,
  output rfda_pkg::ucode_t              ucode_o,
  output logic [rfda_pkg::StepCntW-1:0] step_o
);
  import rfda_pkg::*;

  logic [StepCntW-1:0] step_q, step_d;
  ucode_t uc;

  // microprogram
  always_comb begin
    uc = UcNop;
    case (step_q)
      3'd0: begin
        uc.in_ready = 1'b1;
        uc.jmp      = JMP_WAIT_IN;
      end
      3'd1: begin
        uc.mul_a  = MA_FEED;
        uc.mul_b  = MB_X;
        uc.mul_en = 1'b1;
      end
      3'd2: begin
        uc.acc_op = ACC_LOAD;
        uc.mul_a  = MA_FB1;
        uc.mul_b  = MB_Y1;
        uc.mul_en = 1'b1;
      end
      3'd3: begin
        uc.acc_op = ACC_ADD;
        uc.mul_a  = MA_FB2;
        uc.mul_b  = MB_Y2;
        uc.mul_en = 1'b1;
      end
      3'd4: uc.acc_op = ACC_ADD;
      3'd5: uc.filt_upd = 1'b1;
      3'd6: begin
        uc.mul_a  = MA_GAIN;
        uc.mul_b  = MB_MAG;
        uc.mul_en = 1'b1;
      end
      3'd7: begin
        uc.out_load = 1'b1;
        uc.jmp      = JMP_WAIT_OUT;
      end
      default: uc = UcNop;
    endcase
  end

  always_comb begin
    step_d = step_q;
    case (uc.jmp)
      JMP_NEXT:     step_d = step_q + 1'b1;
      JMP_WAIT_IN:  step_d = in_valid_i ? step_q + 1'b1 : step_q;
      JMP_WAIT_OUT: step_d = status_i.out_busy ? step_q : '0;
      JMP_START:    step_d = '0;
      default:      step_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  assign ucode_o = uc;
  assign step_o  = step_q;

endmodule

>>> rtl/rfda_datapath.sv
`timescale 1ns / 1ps
// Datapath: shared multiplier, 16-bit wrapping accumulator, delay line,
// gain envelope and output register. Depends on rfda_pkg.
module rfda_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rfda_pkg::ucode_t          ucode_i,
  input  rfda_pkg::cfg_t            cfg_i,
  input  logic                      in_fire_i,
  input  logic [rfda_pkg::SmpW-1:0] sample_i,
  input  logic                      gate_i,
  input  logic                      out_ready_i,
  output logic [rfda_pkg::SmpW-1:0] out_data_o,
  output rfda_pkg::dp_status_t      status_o
);
  import rfda_pkg::*;

  logic [SmpW-1:0]  x_q, y1_q, y2_q;
  logic             gate_q;
  logic [GainW-1:0] gain_q, gain_d;
  logic [AccW-1:0]  acc_q;
  logic [ProdW-1:0] prod_q;
  logic [SmpW-1:0]  out_q;
  logic             out_valid_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic [MulBW-1:0]        y1_x, mag;
  logic [CmpW-1:0]         gain_x, step_x;
  logic [SmpW-1:0]         scaled, res;
  logic                    out_busy, out_load;

  // magnitude of the new filter output, 0..128
  assign y1_x = {y1_q[SmpW-1], y1_q};
  assign mag  = y1_q[SmpW-1] ? (~y1_x + 1'b1) : y1_x;

  always_comb begin
    case (ucode_i.mul_a)
      MA_FEED: mul_a = MulAW'($signed(cfg_i.feed));
      MA_FB1:  mul_a = MulAW'($signed(cfg_i.fb1));
      MA_FB2:  mul_a = MulAW'($signed(cfg_i.fb2));
      MA_GAIN: mul_a = $signed({{(MulAW-GainW){1'b0}}, gain_q});
      default: mul_a = '0;
    endcase
    case (ucode_i.mul_b)
      MB_X:    mul_b = MulBW'($signed(x_q));
      MB_Y1:   mul_b = MulBW'($signed(y1_q));
      MB_Y2:   mul_b = MulBW'($signed(y2_q));
      MB_MAG:  mul_b = $signed(mag);
      default: mul_b = '0;
    endcase
  end

  // decay step brought into gain format, saturating subtract
  assign gain_x = CmpW'(gain_q);
  assign step_x = CmpW'((StepXW'(cfg_i.decay) << StepUp) >> StepDn);

  always_comb begin
    gain_d = gain_q;
    if (gate_q) begin
      gain_d = GainOne;
    end else if (gain_q != '0) begin
      gain_d = (gain_x > step_x) ? GainW'(gain_x - step_x) : '0;
    end
  end

  // prod is non-negative here; truncation toward zero comes from the magnitude
  assign scaled = prod_q[GainFracBits +: SmpW];
  assign res    = y1_q[SmpW-1] ? (~scaled + 1'b1) : scaled;

  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = ucode_i.out_load && !out_busy;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      x_q    <= sample_i;
    end
    if (ucode_i.mul_en) begin
      prod_q <= ProdW'(mul_a * mul_b);
    end
    case (ucode_i.acc_op)
      ACC_LOAD: acc_q <= prod_q[AccW-1:0];
      ACC_ADD:  acc_q <= acc_q + prod_q[AccW-1:0];
      ACC_HOLD: acc_q <= acc_q;
      default:  acc_q <= acc_q;
    endcase
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q        <= '0;
      y2_q        <= '0;
      gain_q      <= '0;
      gate_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire_i) begin
        gate_q <= gate_i;
      end
      if (ucode_i.filt_upd) begin
        y1_q   <= acc_q[AccW-1 -: SmpW];
        y2_q   <= y1_q;
        gain_q <= gain_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_data_o         = out_q;
  assign status_o.out_busy  = out_busy;
  assign status_o.out_valid = out_valid_q;

endmodule

>>> rtl/resonant_filter_decay_amp.sv
`timescale 1ns / 1ps
// Top level of the two-pole resonant low-pass with linear-decay amplifier.
// Depends on rfda_pkg, rfda_seq and rfda_datapath.
//
// A sample is accepted in the first step, and the output register is loaded
// in the last step, once the filter taps and the gain have been multiplied.
// An eight-step microprogram drives one shared signed multiplier, which is
// used four times in turn (three filter taps, then the gain). Each product is
// registered before the wrapping 16-bit accumulator or the output stage takes
// it. A new sample is taken on the cycle after the result is loaded, so the
// block never takes a new sample before the current one is through. A stalled
// output holds the sequencer in its last step.
// Coefficients are signed Q8, the decay step is Q16, and the gain envelope
// restarts at full scale whenever the gate bit is high. No clearing pass is
// needed after reset. The user must write configuration only while no sample
// is in flight; the block itself does not enforce this.
module resonant_filter_decay_amp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] sample_in
  input  logic [0:0]                    s_axis_tuser,  // [0] gate
  // output sample stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] sample_out
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rfda_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rfda_pkg::CfgDataW-1:0] cfg_data_i
);
  import rfda_pkg::*;

  cfg_t                cfg_q;
  ucode_t              ucode;
  dp_status_t          status;
  logic [StepCntW-1:0] step;
  logic                in_fire;

  // register file; reset gives instant release and a muted filter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feed  <= '0;
      cfg_q.fb1   <= '0;
      cfg_q.fb2   <= '0;
      cfg_q.decay <= StepW'(1) << StepFrac;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FEED:  cfg_q.feed  <= cfg_data_i[CoefW-1:0];
        REG_FB1:   cfg_q.fb1   <= cfg_data_i[CoefW-1:0];
        REG_FB2:   cfg_q.fb2   <= cfg_data_i[CoefW-1:0];
        REG_DECAY: cfg_q.decay <= cfg_data_i[StepW-1:0];
        default:   cfg_q       <= cfg_q;
      endcase
    end
  end

  assign s_axis_tready = ucode.in_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  rfda_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .ucode_o    (ucode),
    .step_o     (step)
  );

  rfda_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ucode_i     (ucode),
    .cfg_i       (cfg_q),
    .in_fire_i   (in_fire),
    .sample_i    (s_axis_tdata),
    .gate_i      (s_axis_tuser[0]),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .status_o    (status)
  );

  assign m_axis_tvalid = status.out_valid;

`ifndef ASSERT_OFF
  // an accepted beat always starts the filter program
  a_fire_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (step == 3'd1))
    else $error("accepted beat did not start the microprogram");

  // a result appears only from the output step
  a_out_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(step) == StepOut))
    else $error("output valid raised outside the output step");
`endif

endmodule
